// ===== rtl/core/urcs_pkg.sv =====
package urcs_pkg;

   // Defaults for the top-level parameters.
   localparam int WRAP_COUNT_DEFAULT = 150;
   localparam int MSG_MAX_DEFAULT    = 20;

   // Reply pattern characters.
   localparam logic [7:0] CHAR_O      = 8'h4F;
   localparam logic [7:0] CHAR_K      = 8'h4B;
   localparam logic [7:0] CHAR_PROMPT = 8'h3E;
   localparam logic [7:0] CHAR_R      = 8'h72;

   // Link status byte patterns.
   localparam logic [7:0] LINK_UP_B3   = 8'h20;
   localparam logic [7:0] LINK_UP_B2   = 8'h02;
   localparam logic [7:0] LINK_DOWN_B2 = 8'h64;
   localparam logic [7:0] LINK_DOWN_B1 = 8'h01;
   localparam logic [7:0] LINK_DOWN_B0 = 8'h60;

   // Progress codes: READY_LAST once "read" is matched, READY_MATCHED once a reply already lies in the history.
   localparam logic [2:0] READY_LAST    = 3'd4;
   localparam logic [2:0] READY_MATCHED = 3'd5;

   // First four characters of the word "ready" (r, e, a, d), picked by the matched prefix length.
   function automatic logic [7:0] ready_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h72;
         2'd1:    ch = 8'h65;
         2'd2:    ch = 8'h61;
         2'd3:    ch = 8'h64;
         default: ch = 8'h72;
      endcase
      return ch;
   endfunction

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic command_mode;
   } csr_type;

   typedef struct packed {
      logic       ok_seen;
      logic       msg_valid;
      logic [7:0] msg_byte;
      logic [4:0] msg_index;
      logic       msg_last;
      logic       connected;
      logic       buffer_wrapped;
   } rsp_type;

   // Reply tracker state, cleared together with the history.
   typedef struct packed {
      logic [2:0] ready_progress;
      logic       ok_progress;
      logic       zero_blocked;
   } track_type;

   // Feed one history byte to the reply tracker.
   function automatic track_type track_step(input track_type cur, input logic [7:0] ch);
      track_type nxt;
      logic      hit;
      nxt = cur;
      hit = 1'b0;
      if (!cur.zero_blocked && cur.ready_progress < READY_MATCHED) begin
         if (ch == 8'h00) begin
            nxt.zero_blocked   = 1'b1;
            nxt.ok_progress    = 1'b0;
            nxt.ready_progress = 3'd0;
         end else begin
            hit = (ch == CHAR_PROMPT) || (cur.ok_progress && ch == CHAR_K) ||
                  (cur.ready_progress == READY_LAST && ch == ready_char(2'd0) + 8'h07);
            nxt.ok_progress = (ch == CHAR_O);
            if (hit) begin
               nxt.ready_progress = READY_MATCHED;
            end else if (cur.ready_progress < READY_LAST &&
                         ch == ready_char(cur.ready_progress[1:0])) begin
               nxt.ready_progress = cur.ready_progress + 3'd1;
            end else begin
               nxt.ready_progress = (ch == CHAR_R) ? 3'd1 : 3'd0;
            end
         end
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/core/urcs_chan_if.sv =====
interface urcs_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/uart_reply_and_command_sniffer_top.sv =====
// Watches a stream of received serial bytes, one request per byte, and returns one
// result per request. Every request is handled in a single registered pass, so a new
// byte is taken in every clock cycle while the skid entry is empty; a two-entry output
// buffer takes one more request while the result side stalls, then holds requests off
// until a result is taken. In command mode the block pulses ok_seen on "OK", ">" or
// "ready" since the last history clear (a zero byte blocks matching); in normal mode it
// extracts length-prefixed messages and marks the last byte. The connected flag tracks
// the link patterns 20 02 00 00 (up) and 64 01 60 (down). All state is in flip-flops
// and is ready right after reset, with no clearing pass.
module uart_reply_and_command_sniffer_top #(
   parameter int WRAP_COUNT = urcs_pkg::WRAP_COUNT_DEFAULT,
   parameter int MSG_MAX    = urcs_pkg::MSG_MAX_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   urcs_chan_if.sink    req_chan,
   urcs_chan_if.source  rsp_chan,
   urcs_chan_if.sink    csr_chan
);

   localparam int POS_W = $clog2(MSG_MAX + 1);
   localparam logic [7:0]       WRAP_LIMIT = 8'(WRAP_COUNT);
   localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(MSG_MAX);

   // Configuration and tracking state.
   logic                  command_mode_ff;
   logic [23:0]           recent_ff, recent_in;
   logic [7:0]            byte_count_ff, byte_count_in;
   urcs_pkg::track_type   track_ff, track_in;
   logic [7:0]            remaining_ff, remaining_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic                  link_ff, link_in;
   urcs_pkg::rsp_type     result;

   // Output register with a skid entry behind it.
   logic                  out_valid_ff, skid_valid_ff;
   urcs_pkg::rsp_type     out_data_ff, skid_data_ff;

   logic accept;
   logic pop;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // Next state and result for the byte on the request side.
   always_comb begin
      logic [7:0]          ch;
      logic [7:0]          kept;
      logic [7:0]          b1, b2, b3;
      urcs_pkg::track_type tr;
      logic [7:0]          cnt;
      logic [7:0]          rem;
      logic [POS_W-1:0]    pos;
      logic                lnk;

      ch  = req_chan.payload.rx_byte;
      b1  = recent_ff[7:0];
      b2  = recent_ff[15:8];
      b3  = recent_ff[23:16];
      tr  = track_ff;
      cnt = byte_count_ff;
      rem = remaining_ff;
      pos = position_ff;
      kept = ch;
      result = '0;

      if (command_mode_ff) begin
         tr = urcs_pkg::track_step(track_ff, ch);
         if (tr.ready_progress >= urcs_pkg::READY_MATCHED) begin
            result.ok_seen = 1'b1;
            tr  = '0;
            cnt = 8'd0;
         end else begin
            if (cnt != 8'hFF) begin
               cnt = cnt + 8'd1;
            end
            if (cnt >= WRAP_LIMIT) begin
               tr  = '0;
               cnt = 8'd0;
               result.buffer_wrapped = 1'b1;
            end
         end
      end else begin
         // A byte arriving at a full history is treated as a zero.
         if (cnt >= WRAP_LIMIT) begin
            tr   = '0;
            cnt  = 8'd0;
            kept = 8'd0;
            result.buffer_wrapped = 1'b1;
         end
         tr = urcs_pkg::track_step(tr, kept);
         if (rem != 8'd0) begin
            rem = rem - 8'd1;
            if (pos < POS_LIMIT) begin
               result.msg_valid = 1'b1;
               result.msg_byte  = kept;
               result.msg_index = 5'(pos);
               result.msg_last  = (rem == 8'd0);
               pos = pos + POS_W'(1);
            end
         end
         // Two zeros then a nonzero byte announce a message length.
         if (cnt > 8'd3 && b2 == 8'd0 && b1 == 8'd0 && kept != 8'd0) begin
            rem = kept;
            pos = '0;
         end
         if (cnt != 8'hFF) begin
            cnt = cnt + 8'd1;
         end
      end

      // Link status follows the raw bytes.
      lnk = link_ff;
      if (b3 == urcs_pkg::LINK_UP_B3 && b2 == urcs_pkg::LINK_UP_B2 &&
          b1 == 8'd0 && ch == 8'd0) begin
         lnk = 1'b1;
      end
      if (b2 == urcs_pkg::LINK_DOWN_B2 && b1 == urcs_pkg::LINK_DOWN_B1 &&
          ch == urcs_pkg::LINK_DOWN_B0) begin
         lnk = 1'b0;
      end
      result.connected = lnk;

      recent_in     = {recent_ff[15:0], ch};
      byte_count_in = cnt;
      track_in      = tr;
      remaining_in  = rem;
      position_in   = pos;
      link_in       = lnk;
   end

   // State updates on each accepted request and each configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         command_mode_ff <= 1'b1;
         recent_ff       <= '0;
         byte_count_ff   <= '0;
         track_ff        <= '0;
         remaining_ff    <= '0;
         position_ff     <= '0;
         link_ff         <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            command_mode_ff <= csr_chan.payload.command_mode;
         end
         if (accept) begin
            recent_ff     <= recent_in;
            byte_count_ff <= byte_count_in;
            track_ff      <= track_in;
            remaining_ff  <= remaining_in;
            position_ff   <= position_in;
            link_ff       <= link_in;
         end
      end
   end

   // Output register and skid entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            out_data_ff <= result;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= result;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= result;
         end
      end
   end

endmodule

// ===== rtl/core/urcs_checker.sv =====
module urcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input urcs_pkg::rsp_type rsp_payload
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Taking a result leaves the skid entry empty, so the request side is ready next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("request side blocked after result was taken");

   // A reply pulse belongs to command mode and a message byte to normal mode; a reply pulse never comes with a wrap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.ok_seen &&
                      (rsp_payload.msg_valid || rsp_payload.buffer_wrapped)))
      else $error("reply pulse together with message byte or wrap");

   // Message fields are zero when no message byte is carried.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.msg_valid |->
         rsp_payload.msg_byte == 8'd0 && rsp_payload.msg_index == 5'd0 &&
         !rsp_payload.msg_last)
      else $error("message fields set without a message byte");

endmodule

bind uart_reply_and_command_sniffer_top urcs_checker u_urcs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

// ===== verif/uart_reply_and_command_sniffer_top_tb.sv =====
`timescale 1ns / 100ps

module uart_reply_and_command_sniffer_top_tb;

   localparam int WRAP_LIMIT    = urcs_pkg::WRAP_COUNT_DEFAULT;
   localparam int MSG_LIMIT     = urcs_pkg::MSG_MAX_DEFAULT;
   localparam int RANDOM_BYTES  = 1300;
   localparam int SETTLE_CYCLES = 20;

   // Letters r, e, a, d of the word "ready", lowest byte first, and its final letter.
   localparam logic [31:0] READY_PREFIX = {8'h64, 8'h61, 8'h65, 8'h72};
   localparam logic [7:0]  CHAR_Y       = 8'h79;

   typedef enum logic [1:0] {
      STIM_BYTE,
      STIM_MODE,
      STIM_DRAIN
   } stim_kind_type;

   typedef struct packed {
      stim_kind_type kind;
      logic [7:0]    data;
      int unsigned   gap;
   } stim_item_type;

   // Shadow copy of the sniffer state and its mode register.
   typedef struct packed {
      logic        cmd_mode;
      logic [23:0] last_three;
      logic [7:0]  hist_count;
      logic [2:0]  ready_pos;
      logic        saw_o;
      logic        zero_seen;
      logic [7:0]  msg_left;
      logic [4:0]  msg_pos;
      logic        link;
   } sniff_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urcs_chan_if #(.payload_type(urcs_pkg::req_type)) req_if ();
   urcs_chan_if #(.payload_type(urcs_pkg::rsp_type)) rsp_if ();
   urcs_chan_if #(.payload_type(urcs_pkg::csr_type)) csr_if ();

   uart_reply_and_command_sniffer_top #(
      .WRAP_COUNT(WRAP_LIMIT),
      .MSG_MAX   (MSG_LIMIT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   always #2 clock = ~clock;

   stim_item_type     byte_stream_q[$];
   urcs_pkg::rsp_type predicted_q[$];
   sniff_state_type   sniff;

   int          results_owed = 0;
   int unsigned gap_left     = 0;
   int unsigned quiet_cycles = 0;
   bit          sender_calm  = 1'b0;
   int unsigned bytes_queued = 0;

   int unsigned stall_left    = 0;
   int unsigned stretch_left  = 0;
   bit          sink_calm     = 1'b0;

   int unsigned error_count     = 0;
   int unsigned results_checked = 0;
   int unsigned requests_sent   = 0;
   int unsigned mode_writes     = 0;
   int unsigned ok_count        = 0;
   int unsigned msg_count       = 0;
   int unsigned last_count      = 0;
   int unsigned wrap_count      = 0;

   // Idle length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic log_error(input string what);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", what);
   endtask

   function automatic string fmt_result(input urcs_pkg::rsp_type r);
      return $sformatf("ok=%b valid=%b byte=%h index=%0d last=%b conn=%b wrap=%b",
                       r.ok_seen, r.msg_valid, r.msg_byte, r.msg_index, r.msg_last,
                       r.connected, r.buffer_wrapped);
   endfunction

   // Clearing the history leaves the link, the message and the raw bytes alone.
   function automatic sniff_state_type clear_history(input sniff_state_type s);
      s.hist_count = 8'd0;
      s.ready_pos  = 3'd0;
      s.saw_o      = 1'b0;
      s.zero_seen  = 1'b0;
      return s;
   endfunction

   // Advance the reply matcher by one history byte.
   function automatic sniff_state_type feed_tracker(input sniff_state_type s,
                                                    input logic [7:0] ch);
      logic hit;
      if (s.zero_seen || s.ready_pos >= urcs_pkg::READY_MATCHED) return s;
      if (ch == 8'h00) begin
         s.zero_seen = 1'b1;
         s.saw_o     = 1'b0;
         s.ready_pos = 3'd0;
         return s;
      end
      hit = (ch == urcs_pkg::CHAR_PROMPT) || (s.saw_o && ch == urcs_pkg::CHAR_K) ||
            (s.ready_pos == 3'd4 && ch == CHAR_Y);
      s.saw_o = (ch == urcs_pkg::CHAR_O);
      if (hit) begin
         s.ready_pos = urcs_pkg::READY_MATCHED;
      end else if (s.ready_pos < 3'd4 && ch == READY_PREFIX[8 * s.ready_pos[1:0] +: 8]) begin
         s.ready_pos = s.ready_pos + 3'd1;
      end else begin
         s.ready_pos = (ch == urcs_pkg::CHAR_R) ? 3'd1 : 3'd0;
      end
      return s;
   endfunction

   // Work out the outputs for one received byte and update the shadow state.
   function automatic urcs_pkg::rsp_type predict_byte(input logic [7:0] c);
      urcs_pkg::rsp_type r;
      logic [7:0]        b1, b2, b3, kept;
      r  = '0;
      b1 = sniff.last_three[7:0];
      b2 = sniff.last_three[15:8];
      b3 = sniff.last_three[23:16];
      if (sniff.cmd_mode) begin
         sniff = feed_tracker(sniff, c);
         if (sniff.ready_pos >= urcs_pkg::READY_MATCHED) begin
            r.ok_seen = 1'b1;
            sniff     = clear_history(sniff);
         end else begin
            if (sniff.hist_count != 8'hFF) sniff.hist_count = sniff.hist_count + 8'd1;
            if (sniff.hist_count >= WRAP_LIMIT) begin
               sniff            = clear_history(sniff);
               r.buffer_wrapped = 1'b1;
            end
         end
      end else begin
         kept = c;
         // A full history is cleared first and the byte is then lost as a zero.
         if (sniff.hist_count >= WRAP_LIMIT) begin
            sniff            = clear_history(sniff);
            r.buffer_wrapped = 1'b1;
            kept             = 8'h00;
         end
         sniff = feed_tracker(sniff, kept);
         if (sniff.msg_left != 8'd0) begin
            sniff.msg_left = sniff.msg_left - 8'd1;
            if (sniff.msg_pos < MSG_LIMIT) begin
               r.msg_valid   = 1'b1;
               r.msg_byte    = kept;
               r.msg_index   = sniff.msg_pos;
               r.msg_last    = (sniff.msg_left == 8'd0);
               sniff.msg_pos = sniff.msg_pos + 5'd1;
            end
         end
         // Two zeros and a nonzero byte announce a new message length.
         if (sniff.hist_count > 8'd3 && b2 == 8'h00 && b1 == 8'h00 && kept != 8'h00) begin
            sniff.msg_left = kept;
            sniff.msg_pos  = 5'd0;
         end
         if (sniff.hist_count != 8'hFF) sniff.hist_count = sniff.hist_count + 8'd1;
      end
      if (b3 == urcs_pkg::LINK_UP_B3 && b2 == urcs_pkg::LINK_UP_B2 &&
          b1 == 8'h00 && c == 8'h00)
         sniff.link = 1'b1;
      if (b2 == urcs_pkg::LINK_DOWN_B2 && b1 == urcs_pkg::LINK_DOWN_B1 &&
          c == urcs_pkg::LINK_DOWN_B0)
         sniff.link = 1'b0;
      sniff.last_three = {sniff.last_three[15:0], c};
      r.connected      = sniff.link;
      return r;
   endfunction

   // Stimulus queue helpers.
   task automatic queue_item(input stim_kind_type kind, input logic [7:0] data);
      stim_item_type it;
      it.kind = kind;
      it.data = data;
      it.gap  = pick_gap(sender_calm);
      byte_stream_q.push_back(it);
      if (kind == STIM_BYTE) bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_item(STIM_BYTE, s[i]);
   endtask

   task automatic push_link(input bit up);
      if (up) begin
         queue_item(STIM_BYTE, urcs_pkg::LINK_UP_B3);
         queue_item(STIM_BYTE, urcs_pkg::LINK_UP_B2);
         queue_item(STIM_BYTE, 8'h00);
         queue_item(STIM_BYTE, 8'h00);
      end else begin
         queue_item(STIM_BYTE, urcs_pkg::LINK_DOWN_B2);
         queue_item(STIM_BYTE, urcs_pkg::LINK_DOWN_B1);
         queue_item(STIM_BYTE, urcs_pkg::LINK_DOWN_B0);
      end
   endtask

   // A reply word, whole or broken off.
   task automatic push_reply_token();
      case ($urandom_range(0, 5))
         0: push_text("OK");
         1: push_text(">");
         2: push_text("ready");
         3: begin
            push_text("rea");
            queue_item(STIM_BYTE, 8'($urandom_range(0, 255)));
         end
         4: begin
            push_text("O");
            queue_item(STIM_BYTE, 8'($urandom_range(0, 255)));
         end
         default: push_text("readr");
      endcase
   endtask

   // Request driver: sends bytes and mode writes, pausing for drains.
   always @(posedge clock) begin : drive_requests
      logic          req_v, csr_v, csr_d;
      logic [7:0]    req_d;
      stim_item_type it;
      req_v = req_if.valid;
      req_d = req_if.payload.rx_byte;
      csr_v = csr_if.valid;
      csr_d = csr_if.payload.command_mode;
      if (reset) begin
         req_v = 1'b0;
         csr_v = 1'b0;
      end else begin
         if (results_owed == 0 && !(req_if.valid && req_if.ready) && !req_if.valid)
            quiet_cycles++;
         else
            quiet_cycles = 0;
         if (req_v && req_if.ready) req_v = 1'b0;
         if (csr_v && csr_if.ready) csr_v = 1'b0;
         if (!req_v && !csr_v) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (byte_stream_q.size() != 0) begin
               it = byte_stream_q[0];
               case (it.kind)
                  STIM_BYTE: begin
                     void'(byte_stream_q.pop_front());
                     req_v    = 1'b1;
                     req_d    = it.data;
                     gap_left = it.gap;
                  end
                  STIM_MODE: begin
                     if (quiet_cycles >= 2) begin
                        void'(byte_stream_q.pop_front());
                        csr_v    = 1'b1;
                        csr_d    = it.data[0];
                        gap_left = it.gap;
                     end
                  end
                  default: begin
                     if (quiet_cycles >= 2) begin
                        void'(byte_stream_q.pop_front());
                        gap_left = it.gap;
                     end
                  end
               endcase
            end
         end
      end
      req_if.valid                <= req_v;
      req_if.payload.rx_byte      <= req_d;
      csr_if.valid                <= csr_v;
      csr_if.payload.command_mode <= csr_d;
   end

   // Result sink: stretches of steady acceptance and of random stalls.
   always @(posedge clock) begin : drive_result_ready
      logic nxt_ready;
      if (reset) begin
         nxt_ready = 1'b0;
      end else begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 200);
            sink_calm    = ($urandom_range(0, 3) == 0);
         end else begin
            stretch_left--;
         end
         if (stall_left != 0) begin
            stall_left--;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
            if (!sink_calm && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b0);
         end
      end
      rsp_if.ready <= nxt_ready;
   end

   // Monitor: checks results first, then predicts for newly accepted requests.
   always @(posedge clock) begin : check_results
      urcs_pkg::rsp_type exp_r, got_r;
      int                delta;
      delta = 0;
      if (reset) begin
         sniff          = '0;
         sniff.cmd_mode = 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_r = rsp_if.payload;
            if (predicted_q.size() == 0) begin
               log_error($sformatf("unexpected result: %s", fmt_result(got_r)));
            end else begin
               exp_r = predicted_q.pop_front();
               delta--;
               if (got_r !== exp_r)
                  log_error($sformatf("result %0d: expected %s, got %s", results_checked,
                                      fmt_result(exp_r), fmt_result(got_r)));
               results_checked++;
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            sniff.cmd_mode = csr_if.payload.command_mode;
            mode_writes++;
         end
         if (req_if.valid && req_if.ready) begin
            exp_r = predict_byte(req_if.payload.rx_byte);
            predicted_q.push_back(exp_r);
            delta++;
            requests_sent++;
            if (exp_r.ok_seen) ok_count++;
            if (exp_r.msg_valid) msg_count++;
            if (exp_r.msg_last) last_count++;
            if (exp_r.buffer_wrapped) wrap_count++;
         end
      end
      results_owed <= results_owed + delta;
   end

   // Run limit.
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   // Stimulus and end of run.
   initial begin : main_sequence
      int unsigned directed_bytes, start, phase_len, phase_no, pick, msg_len, n;
      bit          mode, noise_only;
      logic [7:0]  b;

      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready   = 1'b0;

      // Directed: each reply word in command mode.
      push_text("OK");
      push_text(">");
      push_text("ready");
      // A reply seen in normal mode, then a short message with extreme bytes.
      queue_item(STIM_MODE, 8'd0);
      push_text(">");
      queue_item(STIM_BYTE, 8'h11);
      queue_item(STIM_BYTE, 8'h00);
      queue_item(STIM_BYTE, 8'h00);
      queue_item(STIM_BYTE, 8'h03);
      queue_item(STIM_BYTE, 8'hFF);
      queue_item(STIM_BYTE, 8'h80);
      queue_item(STIM_BYTE, 8'h41);
      // The held reply pulses on the first byte back in command mode.
      queue_item(STIM_MODE, 8'd1);
      push_text("z");
      // A zero blocks matching; then link up and link down.
      queue_item(STIM_BYTE, 8'h00);
      push_text("OK");
      push_link(1'b1);
      push_link(1'b0);
      directed_bytes = bytes_queued;

      // Random phases, each opened by a mode write.
      phase_no = 0;
      while (bytes_queued < directed_bytes + RANDOM_BYTES) begin
         mode        = (phase_no < 2) ? phase_no[0] : 1'($urandom_range(0, 1));
         sender_calm = ($urandom_range(0, 4) == 0);
         queue_item(STIM_MODE, {7'd0, mode});
         start = bytes_queued;
         if (mode) begin
            noise_only = ($urandom_range(0, 3) == 0);
            phase_len  = noise_only ? $urandom_range(150, 320) : $urandom_range(40, 200);
            while (bytes_queued - start < phase_len &&
                   bytes_queued < directed_bytes + RANDOM_BYTES) begin
               pick = $urandom_range(0, 99);
               if (noise_only || pick >= 45) begin
                  // Long noise runs avoid the prompt so the history wraps.
                  b = 8'($urandom_range(0, 255));
                  if (noise_only && b == urcs_pkg::CHAR_PROMPT) b = ~b;
                  queue_item(STIM_BYTE, b);
               end else if (pick < 30) begin
                  push_reply_token();
               end else if (pick < 40) begin
                  push_link(1'($urandom_range(0, 1)));
               end else begin
                  queue_item(STIM_BYTE, 8'h00);
               end
               if ($urandom_range(0, 199) == 0) queue_item(STIM_DRAIN, 8'd0);
            end
         end else begin
            phase_len = $urandom_range(60, 260);
            if ($urandom_range(0, 2) == 0) push_reply_token();
            while (bytes_queued - start < phase_len &&
                   bytes_queued < directed_bytes + RANDOM_BYTES) begin
               pick = $urandom_range(0, 99);
               if (pick < 10) begin
                  push_link(1'($urandom_range(0, 1)));
               end else if (pick < 20) begin
                  n = $urandom_range(1, 8);
                  repeat (n) queue_item(STIM_BYTE, 8'($urandom_range(0, 255)));
               end else begin
                  // Framed message: a few leading bytes, two zeros, length, payload.
                  n = $urandom_range(0, 5);
                  repeat (n) queue_item(STIM_BYTE, 8'($urandom_range(0, 255)));
                  queue_item(STIM_BYTE, 8'h00);
                  queue_item(STIM_BYTE, 8'h00);
                  pick = $urandom_range(0, 99);
                  if (pick < 65)      msg_len = $urandom_range(1, MSG_LIMIT);
                  else if (pick < 85) msg_len = $urandom_range(MSG_LIMIT + 1, 40);
                  else if (pick < 93) msg_len = 0;
                  else if (pick < 98) msg_len = $urandom_range(41, 80);
                  else                msg_len = $urandom_range(150, 255);
                  queue_item(STIM_BYTE, msg_len[7:0]);
                  repeat (msg_len) queue_item(STIM_BYTE, 8'($urandom_range(0, 255)));
               end
               if ($urandom_range(0, 199) == 0) queue_item(STIM_DRAIN, 8'd0);
            end
         end
         phase_no++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (!(byte_stream_q.size() == 0 && !req_if.valid && !csr_if.valid &&
               results_owed == 0));
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_q.size() != 0)
         log_error($sformatf("%0d expected results never arrived", predicted_q.size()));

      $display("Checked %0d results for %0d requests (%0d directed) across %0d mode writes.",
               results_checked, requests_sent, directed_bytes, mode_writes);
      $display("Saw %0d reply pulses, %0d message bytes, %0d last marks, %0d wraps; %0d errors.",
               ok_count, msg_count, last_count, wrap_count, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
